FILE: hdl/imh_pkg.sv
`timescale 1ns / 1ps
package imh_pkg;
    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [1:0] CMD_DECREASE = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS,
        S_EXT0,
        S_EXT1,
        S_DEC0,
        S_DEC1,
        S_DEC2,
        S_UP0,
        S_UP1,
        S_UP2,
        S_UP3,
        S_DN0,
        S_DN1,
        S_DN2,
        S_DN3,
        S_DN4,
        S_SWAP,
        S_FIN0,
        S_FIN1,
        S_FIN2,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INSERT,
        OP_EXT_READ_LAST,
        OP_EXT_ROOT,
        OP_DEC_READ_POS,
        OP_DEC_READ_KEY,
        OP_DEC_WRITE_KEY,
        OP_UP_READ_PARENT,
        OP_UP_READ_PKEY,
        OP_UP_COMPARE,
        OP_DN_READ_LEFT,
        OP_DN_READ_LKEY,
        OP_DN_READ_RIGHT,
        OP_DN_READ_RKEY,
        OP_DN_COMPARE,
        OP_SWAP,
        OP_FIN_READ_ROOT,
        OP_FIN_READ_KEY,
        OP_FIN_LATCH,
        OP_SET_STATUS
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic up_move;
        logic dn_has_left;
        logic dn_has_right;
        logic dn_move;
        logic dn_move_pair;
        logic full;
        logic empty;
        logic absent;
    } dp_stat_t;
endpackage

FILE: hdl/imh_if.sv
`timescale 1ns / 1ps
interface imh_req_if;
    import imh_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic signed [31:0] value;
    logic [AW-1:0] handle;
    modport source (output valid, command, value, handle, input ready);
    modport sink (input valid, command, value, handle, output ready);
endinterface

interface imh_rsp_if;
    import imh_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [AW-1:0] new_handle;
    logic signed [63:0] min_key;
    logic        is_empty;
    logic [CW-1:0] entry_count;
    modport source (output valid, status, new_handle, min_key, is_empty, entry_count,
                    input ready);
    modport sink (input valid, status, new_handle, min_key, is_empty, entry_count,
                  output ready);
endinterface

FILE: hdl/imh_datapath.sv
`timescale 1ns / 1ps
module imh_datapath
    import imh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    input  logic [AW-1:0]      handle,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic [1:0]         status,
    output logic [AW-1:0]      new_handle,
    output logic signed [63:0] min_key,
    output logic               is_empty,
    output logic [CW-1:0]      entry_count
);
    // storage, one synchronous read port each
    logic [63:0]   key_mem [CAPACITY];
    logic [AW-1:0] ord_mem [CAPACITY];
    logic [AW-1:0] pos_mem [CAPACITY];
    logic [CAPACITY-1:0] present_reg;

    logic [63:0]   key_rd;
    logic [AW-1:0] ord_rd, pos_rd;

    logic [1:0]    cmd_reg;
    logic [63:0]   amt_reg;
    logic [AW-1:0] hin_reg;
    logic [CW-1:0] count_reg, nexth_reg;

    // current entry, other entry, left child
    logic [AW-1:0] pos_reg, oth_pos_reg, lpos_reg;
    logic [AW-1:0] h_reg, oth_h_reg, lh_reg;
    logic [63:0]   k_reg, oth_k_reg, lk_reg;

    logic [1:0]    status_reg;
    logic [AW-1:0] newh_reg;
    logic [63:0]   min_reg;

    // the root's key and old handle arrive in the cycle after the root is rebuilt
    logic          ext_key_pend;

    // memory port controls
    logic          key_we, ord_we, pos_we;
    logic [AW-1:0] key_wa, ord_wa, pos_wa, key_ra, ord_ra, pos_ra;
    logic [63:0]   key_wd;
    logic [AW-1:0] ord_wd, pos_wd;
    logic          ord_we2, pos_we2;
    logic [AW-1:0] ord_wa2, ord_wd2, pos_wa2, pos_wd2;

    logic [CW-1:0] up_par, lc, rc;
    assign up_par = ({1'b0, pos_reg} - CW'(1)) >> 1;
    assign lc = {pos_reg, 1'b1};
    assign rc = lc + CW'(1);

    function automatic logic less(input logic [63:0] a, input logic [63:0] b);
        less = $signed(a) < $signed(b);
    endfunction

    // status for the controller
    always_comb
    begin
        stat.up_move      = (pos_reg != '0) && less(k_reg, oth_k_reg);
        stat.dn_has_left  = lc < count_reg;
        stat.dn_has_right = rc < count_reg;
        stat.dn_move      = less(oth_k_reg, k_reg);
        // with both children read: right child on key_rd, left in lk_reg
        stat.dn_move_pair = less(key_rd, lk_reg) ? less(key_rd, k_reg) : less(lk_reg, k_reg);
        stat.full         = (nexth_reg >= CW'(CAPACITY)) || (count_reg >= CW'(CAPACITY));
        stat.empty        = count_reg == '0;
        stat.absent       = ({1'b0, hin_reg} >= nexth_reg) || !present_reg[hin_reg];
    end

    // addresses and write data
    always_comb
    begin
        key_we = 1'b0; ord_we = 1'b0; pos_we = 1'b0;
        ord_we2 = 1'b0; pos_we2 = 1'b0;
        key_wa = h_reg; key_wd = k_reg;
        ord_wa = pos_reg; ord_wd = h_reg;
        pos_wa = h_reg; pos_wd = pos_reg;
        ord_wa2 = oth_pos_reg; ord_wd2 = oth_h_reg;
        pos_wa2 = oth_h_reg; pos_wd2 = oth_pos_reg;
        key_ra = h_reg; ord_ra = pos_reg; pos_ra = hin_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                key_we = 1'b1; key_wa = nexth_reg[AW-1:0]; key_wd = amt_reg;
                ord_we = 1'b1; ord_wa = count_reg[AW-1:0]; ord_wd = nexth_reg[AW-1:0];
                pos_we = 1'b1; pos_wa = nexth_reg[AW-1:0]; pos_wd = count_reg[AW-1:0];
            end
            OP_EXT_READ_LAST: ord_ra = AW'(count_reg - CW'(1));
            OP_EXT_ROOT:
            begin
                ord_ra = '0;
                ord_we = 1'b1; ord_wa = '0; ord_wd = ord_rd;
                pos_we = 1'b1; pos_wa = ord_rd; pos_wd = '0;
                key_ra = ord_rd;
            end
            OP_DEC_READ_POS: pos_ra = hin_reg;
            OP_DEC_READ_KEY: key_ra = hin_reg;
            OP_DEC_WRITE_KEY:
            begin
                key_we = 1'b1; key_wa = hin_reg; key_wd = key_rd - amt_reg;
            end
            OP_UP_READ_PARENT: ord_ra = up_par[AW-1:0];
            OP_UP_READ_PKEY: key_ra = ord_rd;
            OP_DN_READ_LEFT: ord_ra = lc[AW-1:0];
            OP_DN_READ_LKEY: key_ra = ord_rd;
            OP_DN_READ_RIGHT: ord_ra = rc[AW-1:0];
            OP_DN_READ_RKEY: key_ra = ord_rd;
            OP_SWAP:
            begin
                ord_we = 1'b1; ord_wa = oth_pos_reg; ord_wd = h_reg;
                pos_we = 1'b1; pos_wa = h_reg; pos_wd = oth_pos_reg;
                ord_we2 = 1'b1; ord_wa2 = pos_reg; ord_wd2 = oth_h_reg;
                pos_we2 = 1'b1; pos_wa2 = oth_h_reg; pos_wd2 = pos_reg;
            end
            OP_FIN_READ_ROOT: ord_ra = '0;
            OP_FIN_READ_KEY: key_ra = ord_rd;
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_wa] <= key_wd;
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        if (ord_we2)
            ord_mem[ord_wa2] <= ord_wd2;
        if (pos_we)
            pos_mem[pos_wa] <= pos_wd;
        if (pos_we2)
            pos_mem[pos_wa2] <= pos_wd2;
        key_rd <= key_mem[key_ra];
        ord_rd <= ord_mem[ord_ra];
        pos_rd <= pos_mem[pos_ra];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= command;
            amt_reg <= 64'(value);
            hin_reg <= handle;
            status_reg <= ST_OK;
            newh_reg <= '0;
        end
        unique case (cmd.op)
            OP_INSERT:
            begin
                pos_reg <= count_reg[AW-1:0];
                h_reg <= nexth_reg[AW-1:0];
                k_reg <= amt_reg;
                newh_reg <= nexth_reg[AW-1:0];
            end
            OP_EXT_ROOT:
            begin
                pos_reg <= '0;
                h_reg <= ord_rd;
            end
            OP_DEC_READ_KEY:
            begin
                pos_reg <= pos_rd;
                h_reg <= hin_reg;
            end
            OP_DEC_WRITE_KEY: k_reg <= key_rd - amt_reg;
            OP_UP_READ_PARENT: oth_pos_reg <= up_par[AW-1:0];
            OP_UP_READ_PKEY: oth_h_reg <= ord_rd;
            OP_UP_COMPARE: oth_k_reg <= key_rd;
            OP_DN_READ_LEFT: lpos_reg <= lc[AW-1:0];
            OP_DN_READ_LKEY:
            begin
                lh_reg <= ord_rd;
                oth_pos_reg <= lpos_reg;
                oth_h_reg <= ord_rd;
            end
            OP_DN_READ_RIGHT:
            begin
                lk_reg <= key_rd;
                oth_k_reg <= key_rd;
            end
            OP_DN_READ_RKEY: oth_h_reg <= ord_rd;
            OP_DN_COMPARE:
            begin
                // right child wins only when the left is strictly larger
                if (less(key_rd, lk_reg))
                begin
                    oth_pos_reg <= rc[AW-1:0];
                    oth_k_reg <= key_rd;
                end
                else
                begin
                    oth_h_reg <= lh_reg;
                end
            end
            OP_SWAP: pos_reg <= oth_pos_reg;
            OP_FIN_LATCH: min_reg <= (count_reg == '0) ? 64'd0 : key_rd;
            OP_SET_STATUS:
            begin
                status_reg <= cmd.status;
                if (cmd.status != ST_OK || cmd_reg != CMD_INSERT)
                    newh_reg <= '0;
            end
            default: ;
        endcase
        // take the key of the entry moved to the root
        if (ext_key_pend)
            k_reg <= key_rd;
    end

    // counters and present bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            count_reg <= '0;
            nexth_reg <= '0;
            ext_key_pend <= 1'b0;
        end
        else
        begin
            ext_key_pend <= cmd.op == OP_EXT_ROOT;
            if (cmd.op == OP_INSERT)
            begin
                present_reg[nexth_reg[AW-1:0]] <= 1'b1;
                count_reg <= count_reg + CW'(1);
                nexth_reg <= nexth_reg + CW'(1);
            end
            if (cmd.op == OP_EXT_READ_LAST)
                count_reg <= count_reg - CW'(1);
            // drop the old root, read back from position zero
            if (ext_key_pend)
                present_reg[ord_rd] <= 1'b0;
        end
    end

    assign status = status_reg;
    assign new_handle = newh_reg;
    assign min_key = min_reg;
    assign is_empty = count_reg == '0;
    assign entry_count = count_reg;
endmodule

FILE: hdl/imh_control.sv
`timescale 1ns / 1ps
module imh_control
    import imh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic [1:0] command,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output logic     load,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);
    state_t state_reg, state_next;
    logic dec_up_reg, dec_up_next;
    logic dn_cmp_reg, up_mode_reg, dn_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dec_up_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dec_up_reg <= dec_up_next;
        end
    end

    // sequence one request; the root of the heap is read at the end
    always_comb
    begin
        state_next = state_reg;
        dec_up_next = dec_up_reg;
        cmd.op = OP_NONE;
        cmd.status = ST_OK;
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    load = 1'b1;
                    unique case (command)
                        CMD_INSERT: state_next = S_INS;
                        CMD_EXTRACT: state_next = S_EXT0;
                        CMD_DECREASE: state_next = S_DEC0;
                        default: state_next = S_FIN0;
                    endcase
                end
            end
            S_INS:
            begin
                if (stat.full)
                begin
                    cmd.op = OP_SET_STATUS; cmd.status = ST_FULL;
                    state_next = S_FIN0;
                end
                else
                begin
                    cmd.op = OP_INSERT;
                    dec_up_next = 1'b0;
                    state_next = S_UP0;
                end
            end
            S_EXT0:
            begin
                if (stat.empty)
                begin
                    cmd.op = OP_SET_STATUS; cmd.status = ST_EMPTY;
                    state_next = S_FIN0;
                end
                else
                begin
                    cmd.op = OP_EXT_READ_LAST;
                    state_next = S_EXT1;
                end
            end
            S_EXT1:
            begin
                cmd.op = OP_EXT_ROOT;
                state_next = S_DN0;
            end
            S_DEC0:
            begin
                if (stat.absent)
                begin
                    cmd.op = OP_SET_STATUS; cmd.status = ST_ABSENT;
                    state_next = S_FIN0;
                end
                else
                begin
                    cmd.op = OP_DEC_READ_POS;
                    state_next = S_DEC1;
                end
            end
            S_DEC1:
            begin
                cmd.op = OP_DEC_READ_KEY;
                state_next = S_DEC2;
            end
            S_DEC2:
            begin
                cmd.op = OP_DEC_WRITE_KEY;
                dec_up_next = 1'b1;
                state_next = S_UP0;
            end
            S_UP0:
            begin
                cmd.op = OP_UP_READ_PARENT;
                state_next = S_UP1;
            end
            S_UP1:
            begin
                cmd.op = OP_UP_READ_PKEY;
                state_next = S_UP2;
            end
            S_UP2:
            begin
                cmd.op = OP_UP_COMPARE;
                state_next = S_UP3;
            end
            S_UP3:
            begin
                if (stat.up_move)
                    state_next = S_SWAP;
                else if (dec_up_reg)
                begin
                    dec_up_next = 1'b0;
                    state_next = S_DN0;
                end
                else
                    state_next = S_FIN0;
            end
            S_DN0:
            begin
                if (stat.dn_has_left)
                begin
                    cmd.op = OP_DN_READ_LEFT;
                    state_next = S_DN1;
                end
                else
                    state_next = S_FIN0;
            end
            S_DN1:
            begin
                cmd.op = OP_DN_READ_LKEY;
                state_next = S_DN2;
            end
            S_DN2:
            begin
                cmd.op = OP_DN_READ_RIGHT;
                state_next = stat.dn_has_right ? S_DN3 : S_DN4;
            end
            S_DN3:
            begin
                cmd.op = OP_DN_READ_RKEY;
                state_next = S_DN4;
            end
            S_DN4:
            begin
                if (state_reg == S_DN4 && dn_cmp_reg)
                    cmd.op = OP_DN_COMPARE;
                state_next = S_SWAP;
                if (!dn_go)
                    state_next = S_FIN0;
            end
            S_SWAP:
            begin
                cmd.op = OP_SWAP;
                state_next = (up_mode_reg) ? S_UP0 : S_DN0;
            end
            S_FIN0:
            begin
                cmd.op = OP_FIN_READ_ROOT;
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                cmd.op = OP_FIN_READ_KEY;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.op = OP_FIN_LATCH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // down step: compare picks right child only if one was read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_cmp_reg <= 1'b0;
            up_mode_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DN2)
                dn_cmp_reg <= stat.dn_has_right;
            if (state_reg == S_UP0)
                up_mode_reg <= 1'b1;
            if (state_reg == S_DN0)
                up_mode_reg <= 1'b0;
        end
    end
    assign dn_go = dn_cmp_reg ? stat.dn_move_pair : stat.dn_move;
endmodule

FILE: hdl/indexed_min_heap_decrease_key.sv
`timescale 1ns / 1ps
// Indexed binary min-heap with stable handles and decrease-key.
// Requests enter on req (command, value, handle); one response per request
// leaves on rsp (status, new_handle, min_key, is_empty, entry_count).
// Commands: insert, extract minimum, decrease key (subtract value).
// One request is in flight at a time; req.ready is high only while idle.
// An insert writes the new entry at the end and sifts it up, reading the
// parent's handle and key and comparing at each level. An extract moves the
// last entry to the root and sifts it down, reading the left child, then the
// right one if present, at each level. A decrease reads the entry's position
// and key, writes the new key, sifts up, then down. Refused requests only set
// a status. The longest request at 1024 entries is a decrease that sinks from
// the root through every level, since each level needs dependent synchronous
// reads of the order and key memories. After the response is taken the block
// returns to idle before it accepts the next request.
// Reset clears the entry count, the handle counter and the present bits;
// the key and order memories need no clearing.
// The response is held in registers until rsp.ready; a stalled receiver
// holds the block and no new request is taken.
module indexed_min_heap_decrease_key
    import imh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    imh_req_if.sink  req,
    imh_rsp_if.source rsp
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     load;

    imh_control u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .command(req.command), .req_ready(req.ready),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
        .load(load), .cmd(cmd), .stat(stat)
    );

    imh_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .load(load),
        .command(req.command), .value(req.value), .handle(req.handle),
        .cmd(cmd), .stat(stat),
        .status(rsp.status), .new_handle(rsp.new_handle), .min_key(rsp.min_key),
        .is_empty(rsp.is_empty), .entry_count(rsp.entry_count)
    );
endmodule

FILE: bench/imh_tb_if.sv
`timescale 1ns / 1ps
// The block's own interfaces (imh_req_if, imh_rsp_if) are used as they are;
// this file only carries the request record that the stimulus queue holds.
package imh_tb_pkg;
    import imh_pkg::*;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
        logic [AW-1:0]      handle;
    } heap_req_t;
endpackage

FILE: bench/indexed_min_heap_decrease_key_tb.sv
`timescale 1ns / 1ps
module indexed_min_heap_decrease_key_tb;
    import imh_pkg::*;
    import imh_tb_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic [AW-1:0]      new_handle;
        logic signed [63:0] min_key;
        logic               is_empty;
        logic [CW-1:0]      entry_count;
    } heap_rsp_t;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;

    imh_req_if req_ch ();
    imh_rsp_if rsp_ch ();

    indexed_min_heap_decrease_key dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Predictor state: keys per handle, heap order and positions
    logic signed [63:0] key_of [CAPACITY];
    int                 order_at [CAPACITY];
    int                 slot_of [CAPACITY];
    bit                 live [CAPACITY];
    int                 heap_size;
    int                 handles_issued;

    heap_req_t pending_reqs [$];
    heap_rsp_t expected_rsps [$];

    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  stimulus_done;
    int  mismatch_count;
    int  cycle_count;

    function automatic void swap_slots(int a, int b);
        int ha;
        int hb;
        ha = order_at[a];
        hb = order_at[b];
        order_at[a] = hb;
        order_at[b] = ha;
        slot_of[hb] = a;
        slot_of[ha] = b;
    endfunction

    function automatic int sift_toward_root(int pos);
        int up;
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (!(key_of[order_at[pos]] < key_of[order_at[up]]))
                break;
            swap_slots(pos, up);
            pos = up;
        end
        return pos;
    endfunction

    function automatic void sift_toward_leaves(int pos);
        int child;
        while (2 * pos + 1 < heap_size)
        begin
            child = 2 * pos + 1;
            if (child + 1 < heap_size && key_of[order_at[child + 1]] < key_of[order_at[child]])
                child++;
            if (!(key_of[order_at[child]] < key_of[order_at[pos]]))
                break;
            swap_slots(pos, child);
            pos = child;
        end
    endfunction

    // Apply one request to the predictor and return the expected response
    function automatic heap_rsp_t apply_heap_op(heap_req_t r);
        heap_rsp_t          res;
        logic signed [63:0] amount;
        int                 h;
        int                 p;
        res = '0;
        res.status = ST_OK;
        amount = 64'(r.value);
        case (r.command)
            CMD_INSERT:
            begin
                if (handles_issued >= CAPACITY || heap_size >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    h = handles_issued;
                    key_of[h] = amount;
                    order_at[heap_size] = h;
                    slot_of[h] = heap_size;
                    live[h] = 1'b1;
                    heap_size++;
                    handles_issued++;
                    res.new_handle = AW'(h);
                    void'(sift_toward_root(heap_size - 1));
                end
            end
            CMD_EXTRACT:
            begin
                if (heap_size == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    h = order_at[heap_size - 1];
                    live[order_at[0]] = 1'b0;
                    order_at[0] = h;
                    slot_of[h] = 0;
                    heap_size--;
                    sift_toward_leaves(0);
                end
            end
            CMD_DECREASE:
            begin
                h = int'(r.handle);
                if (h >= handles_issued || !live[h])
                    res.status = ST_ABSENT;
                else
                begin
                    key_of[h] = key_of[h] - amount;
                    p = sift_toward_root(slot_of[h]);
                    sift_toward_leaves(p);
                end
            end
            default:
            begin
            end
        endcase
        res.min_key = heap_size != 0 ? key_of[order_at[0]] : 64'sd0;
        res.is_empty = heap_size == 0;
        res.entry_count = CW'(heap_size);
        return res;
    endfunction

    // Track issued handles and live count while generating, to aim requests
    int gen_issued;
    int gen_live;

    task automatic push_req(logic [1:0] cmd, logic signed [31:0] val, int hdl);
        heap_req_t r;
        r.command = cmd;
        r.value = val;
        r.handle = AW'(hdl);
        pending_reqs = {pending_reqs, r};
        if (cmd == CMD_INSERT && gen_issued < CAPACITY)
        begin
            gen_issued++;
            gen_live++;
        end
        else if (cmd == CMD_EXTRACT && gen_live > 0)
            gen_live--;
    endtask

    // Hold until every queued request has been sent, answered and checked
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'($urandom_range(0, 6)) - 3;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        int r;
        int hdl;
        logic [1:0] cmd;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            hdl = gen_issued > 0 ? $urandom_range(0, gen_issued - 1) : 0;
            if (r < 3)
                hdl = $urandom_range(0, CAPACITY - 1);
            if (r < 45)
                cmd = CMD_INSERT;
            else if (r < 70)
                cmd = CMD_EXTRACT;
            else if (r < 97)
                cmd = CMD_DECREASE;
            else
                cmd = CMD_UNUSED;
            push_req(cmd, rand_value(), hdl);
        end
        wait_drained();
    endtask

    // Clock
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        gen_issued = 0;
        gen_live = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty extract, absent handle, unused command, extremes
        push_req(CMD_EXTRACT, 32'sd0, 0);
        push_req(CMD_DECREASE, 32'sd1, 0);
        push_req(CMD_UNUSED, 32'sh7fff_ffff, 1023);
        push_req(CMD_INSERT, 32'sh7fff_ffff, 0);
        push_req(CMD_INSERT, 32'sh8000_0000, 0);
        push_req(CMD_INSERT, 32'sd5, 0);
        push_req(CMD_INSERT, 32'sd5, 0);
        push_req(CMD_DECREASE, 32'sh7fff_ffff, 1);
        push_req(CMD_DECREASE, 32'sh7fff_ffff, 1);
        push_req(CMD_DECREASE, 32'sh8000_0000, 0);
        push_req(CMD_DECREASE, -32'sd10, 2);
        push_req(CMD_DECREASE, 32'sd0, 3);
        push_req(CMD_DECREASE, 32'sd1, 1023);
        push_req(CMD_EXTRACT, 32'sd0, 0);
        push_req(CMD_DECREASE, 32'sd1, 1);
        push_req(CMD_EXTRACT, 32'sd0, 0);
        push_req(CMD_EXTRACT, 32'sd0, 0);
        push_req(CMD_EXTRACT, 32'sd0, 0);
        push_req(CMD_EXTRACT, 32'sd0, 0);
        wait_drained();

        run_phase(120, 0, 0);
        run_phase(120, 62, 0);
        run_phase(120, 0, 62);
        run_phase(120, 7, 7);

        // Use up every handle and hit the no-handles-left case
        while (gen_issued < CAPACITY)
            push_req(CMD_INSERT, rand_value(), 0);
        push_req(CMD_INSERT, 32'sd1, 0);
        push_req(CMD_DECREASE, 32'sd3, 1023);
        push_req(CMD_EXTRACT, 32'sd0, 0);
        wait_drained();
        repeat (20) @(posedge clk);
        stimulus_done = 1'b1;
    end

    // Driver: hold the request until accepted, idle at random between requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.command <= CMD_INSERT;
            req_ch.value <= '0;
            req_ch.handle <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
                expected_rsps = {expected_rsps,
                                 apply_heap_op({req_ch.command, req_ch.value,
                                                req_ch.handle})};
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                heap_req_t r;
                r = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.command <= r.command;
                req_ch.value <= r.value;
                req_ch.handle <= r.handle;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Monitor: check each accepted response, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            mismatch_count <= 0;
            cycle_count <= 0;
        end
        else
        begin
            heap_rsp_t got;
            heap_rsp_t want;
            cycle_count <= cycle_count + 1;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.status, rsp_ch.new_handle, rsp_ch.min_key,
                       rsp_ch.is_empty, rsp_ch.entry_count};
                if (expected_rsps.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected response: status %0d min %0d count %0d",
                                 got.status, got.min_key, got.entry_count);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display({"mismatch: exp status %0d handle %0d min %0d empty %0d",
                                      " count %0d, got %0d %0d %0d %0d %0d"},
                                     want.status, want.new_handle, want.min_key,
                                     want.is_empty, want.entry_count, got.status,
                                     got.new_handle, got.min_key, got.is_empty,
                                     got.entry_count);
                    end
                end
            end
            rsp_ch.ready <= $urandom_range(0, 99) >= receiver_stall_pct;
        end
    end

    // Finish on completion or timeout
    initial
    begin
        wait (stimulus_done || cycle_count >= CYCLE_LIMIT);
        if (!stimulus_done)
            $display("indexed_min_heap_decrease_key_tb: FAIL");
        else if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("indexed_min_heap_decrease_key_tb: PASS");
        else
            $display("indexed_min_heap_decrease_key_tb: FAIL");
        $finish;
    end
endmodule
